// ===== hdl/pvlf_pkg.sv =====
// Package: types, constants and microcode program for the PI velocity loop.
`default_nettype none
package pvlf_pkg;

    localparam int STEP_W = 4;
    localparam int ACC_W  = 58;
    localparam int PROD_W = 49;
    localparam int INT_W  = 26;

    localparam logic [STEP_W-1:0] STEP_IDLE  = 4'd0;
    localparam logic [STEP_W-1:0] STEP_FIRST = 4'd1;
    localparam logic [STEP_W-1:0] STEP_LAST  = 4'd8;

    localparam logic [15:0] FILT_OLD_COEF = 16'd52429;
    localparam logic [15:0] FILT_NEW_COEF = 16'd13107;

    localparam logic [15:0] PROP_GAIN_RST = 16'd29440;
    localparam logic [15:0] INT_GAIN_RST  = 16'd3277;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = -32'sh7FFF_FFFF - 32'sd1;

    localparam logic signed [INT_W-1:0] INT_LIM_POS = 26'sd25600000;
    localparam logic signed [INT_W-1:0] INT_LIM_NEG = -26'sd25600000;

    localparam logic [23:0] DRV_BIAS = 24'hFF_FFFF;

    typedef enum logic [1:0] {
        REG_SETPOINT = 2'd0,
        REG_PROP     = 2'd1,
        REG_INT      = 2'd2
    } reg_idx_t;

    typedef enum logic [1:0] {
        A_OLD  = 2'd0,
        A_NEW  = 2'd1,
        A_PROP = 2'd2,
        A_INT  = 2'd3
    } a_sel_t;

    typedef enum logic [1:0] {
        B_FILT  = 2'd0,
        B_ERR   = 2'd1,
        B_INTEG = 2'd2
    } b_sel_t;

    typedef enum logic [1:0] {
        ACC_HOLD = 2'd0,
        ACC_LOAD = 2'd1,
        ACC_ADD  = 2'd2
    } acc_op_t;

    typedef enum logic [1:0] {
        WR_NONE  = 2'd0,
        WR_FILT  = 2'd1,
        WR_INTEG = 2'd2,
        WR_DRIVE = 2'd3
    } wr_op_t;

    typedef enum logic [1:0] {
        SEQ_NEXT     = 2'd0,
        SEQ_WAIT_IN  = 2'd1,
        SEQ_WAIT_OUT = 2'd2
    } seq_op_t;

    typedef struct packed {
        a_sel_t  a_sel;
        b_sel_t  b_sel;
        acc_op_t acc_op;
        logic    acc_sh8;
        wr_op_t  wr_op;
        seq_op_t seq_op;
    } ucode_t;

    function automatic ucode_t ucode_fetch(input logic [STEP_W-1:0] step);
        ucode_t uw;
        uw = '{A_OLD, B_FILT, ACC_HOLD, 1'b0, WR_NONE, SEQ_NEXT};
        unique case (step)
            4'd0: uw = '{A_OLD,  B_FILT,  ACC_HOLD, 1'b0, WR_NONE,  SEQ_WAIT_IN};
            4'd1: uw = '{A_OLD,  B_FILT,  ACC_HOLD, 1'b0, WR_NONE,  SEQ_NEXT};
            4'd2: uw = '{A_NEW,  B_ERR,   ACC_LOAD, 1'b0, WR_NONE,  SEQ_NEXT};
            4'd3: uw = '{A_OLD,  B_FILT,  ACC_ADD,  1'b1, WR_NONE,  SEQ_NEXT};
            4'd4: uw = '{A_OLD,  B_FILT,  ACC_HOLD, 1'b0, WR_FILT,  SEQ_NEXT};
            4'd5: uw = '{A_PROP, B_FILT,  ACC_HOLD, 1'b0, WR_INTEG, SEQ_NEXT};
            4'd6: uw = '{A_INT,  B_INTEG, ACC_LOAD, 1'b1, WR_NONE,  SEQ_NEXT};
            4'd7: uw = '{A_OLD,  B_FILT,  ACC_ADD,  1'b0, WR_NONE,  SEQ_NEXT};
            4'd8: uw = '{A_OLD,  B_FILT,  ACC_HOLD, 1'b0, WR_DRIVE, SEQ_WAIT_OUT};
            default: uw = '{A_OLD, B_FILT, ACC_HOLD, 1'b0, WR_NONE, SEQ_WAIT_OUT};
        endcase
        return uw;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/pi_velocity_loop_filtered.sv =====
// PI velocity loop with first-order low-pass on the speed error.
//
// Input channel (in_valid/in_stall): one request per control period carrying
// left_count and right_count. Output channel (out_valid/out_stall): one drive
// value per input request, in order.
// Config: APB-style, registers speed_setpoint (0x0), prop_gain (0x4),
// int_gain (0x8); pready is always high. Write only while idle.
// A microcode ROM steps one shared 17x32 multiplier and a 58-bit accumulator
// through the filter, integral and drive terms. An item runs through the program
// steps from input accept until its drive is held in the output register; a new
// request is taken only once the program is back at idle, since every step
// runs through the single multiplier.
// The output register parts the two sides: if the receiver stalls, the result
// stays in place and the next item runs up to its last step, where it waits
// until the output register frees.
// Reset clears the filter and integral state, loads the register defaults
// (setpoint 0, prop_gain 115.0, int_gain about 0.05) and leaves the block idle.
`default_nettype none
module pi_velocity_loop_filtered #(
    parameter int COUNT_BITS = 16
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [3:0]              paddr,
    input  wire logic [31:0]             pwdata,
    output logic      [31:0]             prdata,
    output logic                         pready,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic [COUNT_BITS-1:0]   left_count,
    input  wire logic [COUNT_BITS-1:0]   right_count,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic      [31:0]             drive
);
    import pvlf_pkg::*;

    localparam int SP_W  = COUNT_BITS + 1;
    localparam int ERR_W = COUNT_BITS + 2;

    logic signed [SP_W-1:0]   setpoint_reg, setpoint_next;
    logic [15:0]              prop_gain_reg, prop_gain_next;
    logic [15:0]              int_gain_reg, int_gain_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic signed [ERR_W-1:0]  err_reg, err_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [31:0]       filt_reg, filt_next;
    logic signed [INT_W-1:0]  integ_reg, integ_next;
    logic [31:0]              drive_reg, drive_next;
    logic                     out_valid_reg, out_valid_next;

    ucode_t                   uw;
    reg_idx_t                 cfg_idx;
    logic                     cfg_wr;
    logic                     in_accept;
    logic                     out_free;
    logic                     drive_load;
    logic signed [16:0]       mul_a;
    logic signed [31:0]       mul_b;
    logic signed [ACC_W-1:0]  acc_term;
    logic signed [ACC_W-1:0]  filt_shift;
    logic signed [32:0]       integ_sum;
    logic signed [ACC_W-1:0]  acc_bias;
    logic signed [ACC_W-1:0]  drv_shift;

    assign pready    = 1'b1;
    assign cfg_idx   = reg_idx_t'(paddr[3:2]);
    assign cfg_wr    = psel && penable && pwrite;
    assign in_stall  = (step_reg != STEP_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign uw        = ucode_fetch(step_reg);
    assign drive_load = (uw.wr_op == WR_DRIVE) && out_free;
    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;

    // config
    always_comb
    begin
        setpoint_next  = setpoint_reg;
        prop_gain_next = prop_gain_reg;
        int_gain_next  = int_gain_reg;
        if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_SETPOINT: setpoint_next  = signed'(pwdata[SP_W-1:0]);
                REG_PROP:     prop_gain_next = pwdata[15:0];
                REG_INT:      int_gain_next  = pwdata[15:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_SETPOINT: prdata = 32'(setpoint_reg);
            REG_PROP:     prdata = {16'h0, prop_gain_reg};
            REG_INT:      prdata = {16'h0, int_gain_reg};
            default:      prdata = 32'h0;
        endcase
    end

    // sequencer
    always_comb
    begin
        unique case (uw.seq_op)
            SEQ_WAIT_IN:  step_next = in_accept ? STEP_FIRST : step_reg;
            SEQ_WAIT_OUT: step_next = out_free ? STEP_IDLE : step_reg;
            SEQ_NEXT:     step_next = step_reg + STEP_W'(1);
            default:      step_next = STEP_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        unique case (uw.a_sel)
            A_OLD:   mul_a = signed'({1'b0, FILT_OLD_COEF});
            A_NEW:   mul_a = signed'({1'b0, FILT_NEW_COEF});
            A_PROP:  mul_a = signed'({1'b0, prop_gain_reg});
            A_INT:   mul_a = signed'({1'b0, int_gain_reg});
            default: mul_a = '0;
        endcase
        unique case (uw.b_sel)
            B_FILT:  mul_b = filt_reg;
            B_ERR:   mul_b = 32'(err_reg);
            B_INTEG: mul_b = 32'(integ_reg);
            default: mul_b = '0;
        endcase
    end

    assign prod_next = mul_a * mul_b;
    assign acc_term  = uw.acc_sh8 ? (ACC_W'(prod_reg) <<< 8) : ACC_W'(prod_reg);

    always_comb
    begin
        unique case (uw.acc_op)
            ACC_LOAD: acc_next = acc_term;
            ACC_ADD:  acc_next = acc_reg + acc_term;
            ACC_HOLD: acc_next = acc_reg;
            default:  acc_next = acc_reg;
        endcase
    end

    assign err_next = in_accept
        ? (ERR_W'(signed'(left_count)) + ERR_W'(signed'(right_count))
           - ERR_W'(setpoint_reg))
        : err_reg;

    assign filt_shift = acc_reg >>> 16;
    assign integ_sum  = 33'(integ_reg) + 33'(filt_reg);
    assign acc_bias   = acc_reg + (acc_reg[ACC_W-1] ? signed'(ACC_W'(DRV_BIAS)) : '0);
    assign drv_shift  = acc_bias >>> 24;

    always_comb
    begin
        filt_next = filt_reg;
        if (uw.wr_op == WR_FILT)
        begin
            priority if (filt_shift > S32_MAX)
                filt_next = S32_MAX;
            else if (filt_shift < S32_MIN)
                filt_next = S32_MIN;
            else
                filt_next = filt_shift[31:0];
        end
    end

    always_comb
    begin
        integ_next = integ_reg;
        if (uw.wr_op == WR_INTEG)
        begin
            priority if (integ_sum > INT_LIM_POS)
                integ_next = INT_LIM_POS;
            else if (integ_sum < INT_LIM_NEG)
                integ_next = INT_LIM_NEG;
            else
                integ_next = integ_sum[INT_W-1:0];
        end
    end

    always_comb
    begin
        drive_next = drive_reg;
        if (drive_load)
        begin
            priority if (drv_shift > S32_MAX)
                drive_next = S32_MAX;
            else if (drv_shift < S32_MIN)
                drive_next = S32_MIN;
            else
                drive_next = drv_shift[31:0];
        end
    end

    assign out_valid_next = drive_load || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            setpoint_reg  <= '0;
            prop_gain_reg <= PROP_GAIN_RST;
            int_gain_reg  <= INT_GAIN_RST;
            step_reg      <= STEP_IDLE;
            filt_reg      <= '0;
            integ_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            setpoint_reg  <= setpoint_next;
            prop_gain_reg <= prop_gain_next;
            int_gain_reg  <= int_gain_next;
            step_reg      <= step_next;
            filt_reg      <= filt_next;
            integ_reg     <= integ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg   <= err_next;
        prod_reg  <= prod_next;
        acc_reg   <= acc_next;
        drive_reg <= drive_next;
    end

`ifndef SYNTHESIS
    a_integ_range: assert property (@(posedge clk) disable iff (!rst_n)
        (integ_reg <= INT_LIM_POS) && (integ_reg >= INT_LIM_NEG))
        else $error("integral outside clamp");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (step_reg == STEP_FIRST))
        else $error("accepted request did not start program");

    a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(step_reg == STEP_LAST))
        else $error("result appeared outside last step");

    a_last_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg == STEP_LAST && out_valid_reg && out_stall) |=> (step_reg == STEP_LAST))
        else $error("last step left while output blocked");
`endif

endmodule
`default_nettype wire

// ===== tb/pi_velocity_loop_filtered_test.sv =====
// Self-checking testbench for the filtered PI velocity loop: registers, directed and random requests.
`timescale 1ns / 1ps
module pi_velocity_loop_filtered_test;
    import pvlf_pkg::*;

    localparam logic [3:0] ADDR_UNUSED = 4'hC;
    localparam logic signed [15:0] COUNT_MAX = 16'sh7FFF;
    localparam logic signed [15:0] COUNT_MIN = 16'sh8000;
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES = 64;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS = 230;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [3:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [15:0] left_count = '0;
    logic [15:0] right_count = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [31:0] drive;

    // copy of the loop state and registers
    longint setpoint_reg = 0;
    longint prop_gain_reg = longint'(PROP_GAIN_RST);
    longint int_gain_reg = longint'(INT_GAIN_RST);
    longint filt_state = 0;
    longint integ_state = 0;

    logic signed [31:0] drive_expected_q[$];
    logic signed [31:0] drive_due;

    bit gaps_on = 1'b1;
    bit hold_go = 1'b0;
    int stall_burst = 0;
    int errors = 0;
    int items_sent = 0;
    int drives_checked = 0;
    int input_held_cycles = 0;
    int idle_cycles = 0;

    pi_velocity_loop_filtered dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .left_count (left_count),
        .right_count(right_count),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .drive      (drive)
    );

    always #10 clk = ~clk;

    function automatic longint sat32(input longint x);
        if (x > longint'(S32_MAX))
        begin
            return longint'(S32_MAX);
        end
        if (x < longint'(S32_MIN))
        begin
            return longint'(S32_MIN);
        end
        return x;
    endfunction

    function automatic logic signed [31:0] predict_drive(input logic signed [15:0] l,
                                                        input logic signed [15:0] r);
        longint err;
        longint acc;
        err = longint'(l) + longint'(r) - setpoint_reg;
        acc = longint'(FILT_OLD_COEF) * filt_state + longint'(FILT_NEW_COEF) * (err * 256);
        filt_state = sat32(acc >>> 16);
        integ_state = integ_state + filt_state;
        if (integ_state > longint'(INT_LIM_POS))
        begin
            integ_state = longint'(INT_LIM_POS);
        end
        else if (integ_state < longint'(INT_LIM_NEG))
        begin
            integ_state = longint'(INT_LIM_NEG);
        end
        acc = prop_gain_reg * filt_state * 256 + int_gain_reg * integ_state;
        return 32'(sat32(acc / (64'sd1 <<< 24)));
    endfunction

    function automatic logic [3:0] reg_addr(input reg_idx_t idx);
        return {idx, 2'b00};
    endfunction

    // counts near half the setpoint half the time, else full range or rails
    function automatic logic signed [15:0] pick_count();
        int c;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: c = int'($signed(16'($urandom)));
            9: c = $urandom_range(0, 1) ? 32767 : -32768;
            default: c = int'(setpoint_reg / 2) + int'($urandom_range(0, 1024)) - 512;
        endcase
        if (c > 32767)
        begin
            c = 32767;
        end
        else if (c < -32768)
        begin
            c = -32768;
        end
        return 16'(c);
    endfunction

    task automatic flag_error(input string msg);
        errors++;
        if (errors <= 10)
        begin
            $display("ERROR at %0t: %s", $realtime, msg);
        end
    endtask

    task automatic apb_write(input logic [3:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apb_read(input logic [3:0] addr, output logic [31:0] data);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= addr;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        data = prdata;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_register(input reg_idx_t idx, input int value);
        logic [31:0] wdata;
        wdata = 32'(value);
        apb_write(reg_addr(idx), wdata);
        case (idx)
            REG_SETPOINT: setpoint_reg = longint'($signed(wdata[16:0]));
            REG_PROP: prop_gain_reg = longint'(wdata[15:0]);
            REG_INT: int_gain_reg = longint'(wdata[15:0]);
            default: ;
        endcase
    endtask

    task automatic check_register(input reg_idx_t idx);
        logic [31:0] rd;
        logic [16:0] want;
        logic [16:0] got;
        apb_read(reg_addr(idx), rd);
        case (idx)
            REG_SETPOINT:
            begin
                want = setpoint_reg[16:0];
                got = rd[16:0];
            end
            REG_PROP:
            begin
                want = {1'b0, prop_gain_reg[15:0]};
                got = {1'b0, rd[15:0]};
            end
            default:
            begin
                want = {1'b0, int_gain_reg[15:0]};
                got = {1'b0, rd[15:0]};
            end
        endcase
        if (got !== want)
        begin
            flag_error($sformatf("register %s read 0x%0h, expected 0x%0h", idx.name(), got, want));
        end
    endtask

    task automatic send_request(input logic signed [15:0] l, input logic signed [15:0] r);
        @(negedge clk);
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        in_valid <= 1'b1;
        left_count <= l;
        right_count <= r;
        do
            @(posedge clk);
        while (in_stall);
        drive_expected_q.push_back(predict_drive(l, r));
        items_sent++;
    endtask

    task automatic stop_sending();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (drive_expected_q.size() != 0)
            @(posedge clk);
    endtask

    // block idle before any register write
    task automatic settle();
        stop_sending();
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic test_register_access();
        check_register(REG_SETPOINT);
        check_register(REG_PROP);
        check_register(REG_INT);
        set_register(REG_SETPOINT, -12345);
        set_register(REG_PROP, 32'h0000_A5C3);
        set_register(REG_INT, 32'h0000_5A3C);
        check_register(REG_SETPOINT);
        check_register(REG_PROP);
        check_register(REG_INT);
        // unmapped address must not disturb anything
        apb_write(ADDR_UNUSED, 32'hFFFF_FFFF);
        check_register(REG_SETPOINT);
        check_register(REG_PROP);
        check_register(REG_INT);
    endtask

    task automatic test_directed_extremes();
        settle();
        set_register(REG_SETPOINT, 0);
        set_register(REG_PROP, int'(PROP_GAIN_RST));
        set_register(REG_INT, int'(INT_GAIN_RST));
        // drive the integral up and then down with full-scale counts
        repeat (3) send_request(COUNT_MAX, COUNT_MAX);
        repeat (4) send_request(COUNT_MIN, COUNT_MIN);
        send_request(16'sd0, 16'sd0);
        send_request(-16'sd1, 16'sd0);
        send_request(16'sd1, 16'sd0);
        send_request(COUNT_MAX, COUNT_MIN);
        settle();
        set_register(REG_SETPOINT, 65535);
        set_register(REG_PROP, 65535);
        set_register(REG_INT, 65535);
        repeat (2) send_request(COUNT_MIN, COUNT_MIN);
        settle();
        set_register(REG_SETPOINT, -65536);
        repeat (2) send_request(COUNT_MAX, COUNT_MAX);
        settle();
        set_register(REG_PROP, 0);
        set_register(REG_INT, 0);
        send_request(COUNT_MAX, COUNT_MIN);
        send_request(16'sd12, -16'sd7);
    endtask

    task automatic run_random_phase(input int sp, input int pg, input int ig, input int n);
        settle();
        set_register(REG_SETPOINT, sp);
        set_register(REG_PROP, pg);
        set_register(REG_INT, ig);
        repeat (n) send_request(pick_count(), pick_count());
    endtask

    function automatic int rand_setpoint();
        return int'($urandom_range(0, 131071)) - 65536;
    endfunction

    task automatic test_random_settings();
        run_random_phase(0, int'(PROP_GAIN_RST), int'(INT_GAIN_RST), PHASE_ITEMS);
        run_random_phase(-65536, 0, 0, PHASE_ITEMS);
        run_random_phase(65535, 65535, 65535, PHASE_ITEMS);
        run_random_phase(rand_setpoint(), 65535, 0, PHASE_ITEMS);
        run_random_phase(rand_setpoint(), 0, 65535, PHASE_ITEMS);
        run_random_phase(rand_setpoint(), $urandom_range(0, 65535), $urandom_range(0, 65535),
                         PHASE_ITEMS);
    endtask

    task automatic test_backpressure();
        settle();
        hold_go = 1'b1;
        repeat (24) send_request(pick_count(), pick_count());
        // sender waits for every drive before going on
        stop_sending();
        wait_drained();
        repeat (24) send_request(pick_count(), pick_count());
    endtask

    task automatic test_no_idle();
        run_random_phase(rand_setpoint(), $urandom_range(0, 65535), $urandom_range(0, 65535), 0);
        gaps_on = 1'b0;
        repeat (200) send_request(pick_count(), pick_count());
        stop_sending();
    endtask

    // receiver stall: random bursts, or one long hold on request
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_go)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_go = 1'b0;
            end
            else if (stall_burst > 0)
            begin
                out_stall <= 1'b1;
                stall_burst--;
            end
            else if (gaps_on && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                stall_burst = $urandom_range(1, 3) - 1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (drive_expected_q.size() == 0)
            begin
                flag_error($sformatf("drive %0d with no request outstanding", $signed(drive)));
            end
            else
            begin
                drive_due = drive_expected_q.pop_front();
                drives_checked++;
                if (drive !== drive_due)
                begin
                    flag_error($sformatf("drive %0d, expected %0d", $signed(drive), drive_due));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (in_valid && in_stall)
        begin
            input_held_cycles++;
        end
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("pi_velocity_loop_filtered test failed");
            $finish;
        end
    end

    initial
    begin
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        test_register_access();
        test_directed_extremes();
        test_random_settings();
        test_backpressure();
        test_no_idle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (drive_expected_q.size() != 0)
        begin
            flag_error($sformatf("%0d drive results never arrived", drive_expected_q.size()));
        end
        $display("Ran %0d requests over several gain and setpoint settings, %0d drives checked",
                 items_sent, drives_checked);
        $display("Input held off for %0d cycles, %0d errors", input_held_cycles, errors);
        if (errors == 0)
        begin
            $display("pi_velocity_loop_filtered test passed");
        end
        else
        begin
            $display("pi_velocity_loop_filtered test failed");
        end
        $finish;
    end
endmodule
